FILE: sv/pts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_pkg
// Shared constants and types for the periodic priority task scheduler: field
// positions of the slot setup registers, their reset values and data widths.
// ----------------------------------------------------------------------------
package pts_pkg;

   localparam int NumRegs   = 4;
   localparam int SetupW    = 37;
   localparam int TimeW     = 32;
   localparam int PeriodW   = 16;
   localparam int PhaseW    = 16;
   localparam int PrioW     = 4;
   localparam int CountW    = 32;
   localparam int BitmapW   = 16;
   localparam int OutSlotW  = 2;
   localparam int CsrDataW  = 64;
   localparam int CsrAddrW  = 5;
   localparam int CsrByteW  = 3;

   localparam int PeriodLsb = 0;
   localparam int PhaseLsb  = 16;
   localparam int PrioLsb   = 32;
   localparam int EnableBit = 36;

   localparam int DefTaskSlots      = 4;
   localparam int DefPriorityLevels = 16;

   typedef logic [SetupW-1:0] setup_type;

   localparam setup_type SetupResetValues [NumRegs] = '{
      37'd94489280522,
      37'd90194640916,
      37'd81604378724,
      37'd73014444532
   };

   function automatic logic [PeriodW-1:0] setup_period(input setup_type s);
      return s[PeriodLsb +: PeriodW];
   endfunction

   function automatic logic [PhaseW-1:0] setup_phase(input setup_type s);
      return s[PhaseLsb +: PhaseW];
   endfunction

   function automatic logic [PrioW-1:0] setup_prio(input setup_type s);
      return s[PrioLsb +: PrioW];
   endfunction

endpackage

FILE: sv/periodic_priority_task_scheduler_core.sv
`timescale 1ns / 1ps
// An accepted tick word is held in the input register; its result is registered on fire.
// Throughput: one tick word per cycle when not stalled; the slot scan, the priority pick
// and the state update all fit in the single stage behind the input register.
// Reset (synchronous, active high) loads the setup registers with their
// defaults, reloads each slot's last dispatch time with its phase and clears
// ready flags, run counts, the ready bitmap and the total run count.
// ----------------------------------------------------------------------------
// periodic_priority_task_scheduler_core
// Fixed-priority periodic task scheduler: per tick, marks due slots ready,
// dispatches the highest-priority ready slot and reports counts and bitmap.
// ----------------------------------------------------------------------------
module periodic_priority_task_scheduler_core
   import pts_pkg::*;
#(
   parameter int TASK_SLOTS      = DefTaskSlots,
   parameter int PRIORITY_LEVELS = DefPriorityLevels
) (
   input  logic                clock,
   input  logic                reset,
   // tick input channel
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [TimeW-1:0]    req_tick_time,
   // result channel
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_dispatched,
   output logic [OutSlotW-1:0] rsp_task_slot,
   output logic [PrioW-1:0]    rsp_task_priority,
   output logic [CountW-1:0]   rsp_slot_run_total,
   output logic [CountW-1:0]   rsp_all_runs_total,
   output logic [BitmapW-1:0]  rsp_ready_priorities,
   // configuration port
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [CsrAddrW-1:0] csr_paddr,
   input  logic [CsrDataW-1:0] csr_pwdata,
   output logic [CsrDataW-1:0] csr_prdata,
   output logic                csr_pready
);

   // Slots beyond the register list have no setup and never take part.
   localparam int ActiveSlots = (TASK_SLOTS < NumRegs) ? TASK_SLOTS : NumRegs;
   localparam int SlotW       = (ActiveSlots > 1) ? $clog2(ActiveSlots) : 1;
   localparam int RegIdxW     = $clog2(NumRegs);
   localparam int LevelW      = ($clog2(PRIORITY_LEVELS + 1) > PrioW) ?
                                $clog2(PRIORITY_LEVELS + 1) : PrioW;

   // state
   setup_type          setup_ff [ActiveSlots];
   logic [TimeW-1:0]   last_ff  [ActiveSlots];
   logic [CountW-1:0]  runs_ff  [ActiveSlots];
   logic [ActiveSlots-1:0] ready_ff;
   logic [BitmapW-1:0] map_ff;
   logic [CountW-1:0]  total_ff;

   // pipeline
   logic               s1_valid_ff, s1_valid_in;
   logic [TimeW-1:0]   tick_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               s1_adv, req_acc, fire;

   // scan results
   logic [ActiveSlots-1:0] enable_c;
   logic [ActiveSlots-1:0] ready_now_c;
   logic [PrioW-1:0]   prio_c [ActiveSlots];
   logic [BitmapW-1:0] set_map_c, clr_map_c, map_next_c;
   logic               found_c;
   logic [SlotW-1:0]   best_idx_c;
   logic [PrioW-1:0]   top_prio_c;
   logic [CountW-1:0]  runs_next_c, total_next_c;

   // configuration port
   logic               csr_wr;
   logic [RegIdxW-1:0] csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_idx    = csr_paddr[CsrAddrW-1:CsrByteW];

   always_comb begin
      csr_prdata = '0;
      for (int i = 0; i < ActiveSlots; i++) begin
         if (csr_idx == RegIdxW'(i)) begin
            csr_prdata = CsrDataW'(setup_ff[i]);
         end
      end
   end

   // handshake
   assign s1_adv       = ~rsp_valid_ff | ~rsp_stall;
   assign fire         = s1_valid_ff & s1_adv;
   assign req_stall    = s1_valid_ff & ~s1_adv;
   assign req_acc      = req_valid & ~req_stall;
   assign s1_valid_in  = req_acc | (s1_valid_ff & ~s1_adv);
   assign rsp_valid_in = fire | (rsp_valid_ff & rsp_stall);
   assign rsp_valid    = rsp_valid_ff;

   // Due test, ready bitmap update and priority pick for the tick in stage 1.
   always_comb begin
      set_map_c   = '0;
      found_c     = 1'b0;
      best_idx_c  = '0;
      top_prio_c  = '0;
      for (int i = 0; i < ActiveSlots; i++) begin
         enable_c[i]    = setup_ff[i][EnableBit];
         prio_c[i]      = setup_prio(setup_ff[i]);
         // The sum is one bit wider so that it never wraps.
         ready_now_c[i] = ready_ff[i] |
                          (enable_c[i] &
                           ({1'b0, tick_ff} >= ({1'b0, last_ff[i]} +
                                                (TimeW + 1)'(setup_period(setup_ff[i])))));
         if (enable_c[i] && !ready_ff[i] && ready_now_c[i] &&
             LevelW'(prio_c[i]) < LevelW'(PRIORITY_LEVELS)) begin
            set_map_c = set_map_c | (BitmapW'(1) << prio_c[i]);
         end
      end
      // A slot that was already ready sets its bit again when due.
      for (int i = 0; i < ActiveSlots; i++) begin
         if (enable_c[i] && ready_ff[i] &&
             ({1'b0, tick_ff} >= ({1'b0, last_ff[i]} +
                                  (TimeW + 1)'(setup_period(setup_ff[i])))) &&
             LevelW'(prio_c[i]) < LevelW'(PRIORITY_LEVELS)) begin
            set_map_c = set_map_c | (BitmapW'(1) << prio_c[i]);
         end
      end
      // Ascending scan with a strict compare keeps the lowest slot on a tie.
      for (int i = 0; i < ActiveSlots; i++) begin
         if (enable_c[i] && ready_now_c[i] && (!found_c || prio_c[i] > top_prio_c)) begin
            found_c     = 1'b1;
            best_idx_c  = SlotW'(i);
            top_prio_c  = prio_c[i];
         end
      end
      clr_map_c = '0;
      if (found_c && LevelW'(top_prio_c) < LevelW'(PRIORITY_LEVELS)) begin
         clr_map_c = BitmapW'(1) << top_prio_c;
      end
      map_next_c   = (map_ff | set_map_c) & ~clr_map_c;
      runs_next_c  = runs_ff[best_idx_c] + CountW'(1);
      total_next_c = total_ff + CountW'(found_c);
   end

   // control and scheduler state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         ready_ff     <= '0;
         map_ff       <= '0;
         total_ff     <= '0;
         for (int i = 0; i < ActiveSlots; i++) begin
            setup_ff[i] <= SetupResetValues[i];
            last_ff[i]  <= TimeW'(setup_phase(SetupResetValues[i]));
            runs_ff[i]  <= '0;
         end
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            map_ff   <= map_next_c;
            total_ff <= total_next_c;
         end
         for (int i = 0; i < ActiveSlots; i++) begin
            if (csr_wr && csr_idx == RegIdxW'(i)) begin
               setup_ff[i] <= csr_pwdata[SetupW-1:0];
               last_ff[i]  <= TimeW'(setup_phase(csr_pwdata[SetupW-1:0]));
               runs_ff[i]  <= '0;
               ready_ff[i] <= 1'b0;
            end else if (fire) begin
               ready_ff[i] <= ready_now_c[i] & ~(found_c & (best_idx_c == SlotW'(i)));
               if (found_c && best_idx_c == SlotW'(i)) begin
                  last_ff[i] <= tick_ff;
                  runs_ff[i] <= runs_next_c;
               end
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_acc) begin
         tick_ff <= req_tick_time;
      end
      if (fire) begin
         rsp_dispatched       <= found_c;
         rsp_task_slot        <= OutSlotW'(best_idx_c);
         rsp_task_priority    <= top_prio_c;
         rsp_slot_run_total   <= found_c ? runs_next_c : '0;
         rsp_all_runs_total   <= total_next_c;
         rsp_ready_priorities <= map_next_c;
      end
   end

endmodule
